/* src/nth_ugly_number_generator_defines.svh */
// Assertion macros shared by the ugly number generator modules.
`ifndef NTH_UGLY_NUMBER_GENERATOR_DEFINES_SVH
`define NTH_UGLY_NUMBER_GENERATOR_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define NUG_ASSERT_NOW(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define NUG_ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* src/nug_pkg.sv */
// Types and constants shared by the ugly number generator modules.
`timescale 1ns / 1ps

package nug_pkg;

	localparam int POS_W  = 11;
	localparam int VAL_W  = 31;
	localparam int PROD_W = 34;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INIT,
		ST_RD2,
		ST_RD3,
		ST_RD5,
		ST_WR,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RSEL_P2,
		RSEL_P3,
		RSEL_P5
	} rsel_t;

	typedef struct packed {
		logic  capture_pos;
		logic  init;
		rsel_t rd_sel;
		logic  cap2;
		logic  cap3;
		logic  step;
		logic  load_out;
	} cmd_t;

	typedef struct packed {
		logic pos_bad;
		logic built;
		logic out_free;
	} sts_t;

endpackage

/* src/nug_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module nug_ram #(
	parameter int DATA_W = 31,
	parameter int DEPTH  = 1024,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem_q [DEPTH];
	logic [DATA_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

/* src/nug_dp.sv */
// Datapath: sequence store, read pointers, candidate products, minimum and output word.
`timescale 1ns / 1ps
`include "nth_ugly_number_generator_defines.svh"

module nug_dp #(
	parameter int MAX_N = 1024
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic [nug_pkg::POS_W-1:0]      position,
	input  logic                           out_stall,
	output logic                           out_valid,
	output logic [nug_pkg::VAL_W-1:0]      value,
	output logic                           error,
	input  nug_pkg::cmd_t                  cmd,
	output nug_pkg::sts_t                  sts
);

	import nug_pkg::*;

	localparam int AW = (MAX_N > 1) ? $clog2(MAX_N) : 1;
	localparam int CW = $clog2(MAX_N + 1);

	logic [AW-1:0]     p2_q, p3_q, p5_q;
	logic [CW-1:0]     i_q, n_q;
	logic              err_q;
	logic [VAL_W-1:0]  last_q;
	logic [PROD_W-1:0] c2_q, c3_q;
	logic              out_valid_q;
	logic [VAL_W-1:0]  value_q;
	logic              error_q;

	logic [VAL_W-1:0]  rdata;
	logic [AW-1:0]     raddr;
	logic              we;
	logic [AW-1:0]     waddr;
	logic [VAL_W-1:0]  wdata;
	logic [PROD_W-1:0] c5, m12, m;

	always_comb begin
		case (cmd.rd_sel)
			RSEL_P2: raddr = p2_q;
			RSEL_P3: raddr = p3_q;
			RSEL_P5: raddr = p5_q;
			default: raddr = p2_q;
		endcase
	end

	assign c5  = {3'b000, rdata} + {1'b0, rdata, 2'b00};
	assign m12 = (c2_q < c3_q) ? c2_q : c3_q;
	assign m   = (m12 < c5) ? m12 : c5;

	assign we    = cmd.init | cmd.step;
	assign waddr = cmd.init ? '0 : i_q[AW-1:0];
	assign wdata = cmd.init ? VAL_W'(1) : m[VAL_W-1:0];

	nug_ram #(
		.DATA_W(VAL_W),
		.DEPTH (MAX_N)
	) u_store (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p2_q <= '0;
			p3_q <= '0;
			p5_q <= '0;
			i_q  <= '0;
		end else if (cmd.init) begin
			p2_q <= '0;
			p3_q <= '0;
			p5_q <= '0;
			i_q  <= CW'(1);
		end else if (cmd.step) begin
			if (m == c2_q) begin
				p2_q <= p2_q + AW'(1);
			end
			if (m == c3_q) begin
				p3_q <= p3_q + AW'(1);
			end
			if (m == c5) begin
				p5_q <= p5_q + AW'(1);
			end
			i_q <= i_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture_pos) begin
			err_q <= sts.pos_bad;
			n_q   <= CW'(position);
		end
		if (cmd.init) begin
			last_q <= VAL_W'(1);
		end else if (cmd.step) begin
			last_q <= m[VAL_W-1:0];
		end
		if (cmd.cap2) begin
			c2_q <= {2'b00, rdata, 1'b0};
		end
		if (cmd.cap3) begin
			c3_q <= {3'b000, rdata} + {2'b00, rdata, 1'b0};
		end
		if (cmd.load_out) begin
			value_q <= err_q ? '0 : last_q;
			error_q <= err_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign sts.pos_bad  = (position == '0) ||
		({1'b0, position} > (POS_W + 1)'(MAX_N));
	assign sts.built    = (i_q == n_q);
	assign sts.out_free = !out_valid_q || !out_stall;

	assign out_valid = out_valid_q;
	assign value     = value_q;
	assign error     = error_q;

	`NUG_ASSERT_NOW(a_ptr_behind_fill, cmd.step,
		(CW'(p2_q) < i_q) && (CW'(p3_q) < i_q) && (CW'(p5_q) < i_q),
		"read pointer reached the fill position")
	`NUG_ASSERT_NEXT(a_seq_increasing, cmd.step, last_q > $past(last_q),
		"sequence word not above the previous one")
	`NUG_ASSERT_NOW(a_load_when_free, cmd.load_out, !out_valid_q || !out_stall,
		"output word overwritten while stalled")

endmodule

/* src/nug_ctrl.sv */
// Controller: state machine that sequences store reads, writes and the output word.
`timescale 1ns / 1ps
`include "nth_ugly_number_generator_defines.svh"

module nug_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  nug_pkg::sts_t sts,
	output nug_pkg::cmd_t cmd
);

	import nug_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = sts.pos_bad ? ST_DONE : ST_INIT;
				end
			end
			ST_INIT: state_d = ST_RD2;
			ST_RD2:  state_d = sts.built ? ST_DONE : ST_RD3;
			ST_RD3:  state_d = ST_RD5;
			ST_RD5:  state_d = ST_WR;
			ST_WR:   state_d = ST_RD2;
			ST_DONE: begin
				if (sts.out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		cmd.rd_sel = RSEL_P2;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall        = 1'b0;
				cmd.capture_pos = in_valid;
			end
			ST_INIT: cmd.init = 1'b1;
			ST_RD2:  cmd.rd_sel = RSEL_P2;
			ST_RD3: begin
				cmd.rd_sel = RSEL_P3;
				cmd.cap2   = 1'b1;
			end
			ST_RD5: begin
				cmd.rd_sel = RSEL_P5;
				cmd.cap3   = 1'b1;
			end
			ST_WR:   cmd.step = 1'b1;
			ST_DONE: cmd.load_out = sts.out_free;
			default: in_stall = 1'b1;
		endcase
	end

	`NUG_ASSERT_NEXT(a_accept_starts_work, in_valid && !in_stall, state_q != ST_IDLE,
		"accepted word did not start a request")

endmodule

/* src/nth_ugly_number_generator.sv */
// Top level of the n-th ugly number generator.
`timescale 1ns / 1ps

// Returns the n-th number whose only prime factors are 2, 3 and 5 (1 is the
// first) for each position word. Position 0 or above MAX_N returns value 0
// with error set, going from accept straight to the done state. A valid
// position n rebuilds the sequence in a MAX_N-entry store and then puts the
// result in the output register: each new entry takes four steps, three
// reads of the single store read port (one per pointer) and one write. One
// request is in flight at a time; the next one is accepted as soon as the
// previous result sits in the output register, even if it is stalled.
module nth_ugly_number_generator #(
	parameter int MAX_N = 1024
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [nug_pkg::POS_W-1:0] position,
	output logic                      out_valid,
	input  logic                      out_stall,
	output logic [nug_pkg::VAL_W-1:0] value,
	output logic                      error
);

	import nug_pkg::*;

	cmd_t cmd;
	sts_t sts;

	nug_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	nug_dp #(
		.MAX_N(MAX_N)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.position (position),
		.out_stall(out_stall),
		.out_valid(out_valid),
		.value    (value),
		.error    (error),
		.cmd      (cmd),
		.sts      (sts)
	);

endmodule
